// ===== design/vfvc_pkg.sv =====
// Shared types and constants for the voxel face visibility culler.
// No dependencies; imported by vfvc_face_pick and the core.
`default_nettype none

package vfvc_pkg;

    localparam int NUM_DIRS = 6;

    typedef logic [2:0] t_dir;

    // Neighbor direction codes, in scan order
    localparam t_dir DIR_POS_Y = 3'd0;
    localparam t_dir DIR_NEG_Y = 3'd1;
    localparam t_dir DIR_NEG_X = 3'd2;
    localparam t_dir DIR_POS_X = 3'd3;
    localparam t_dir DIR_NEG_Z = 3'd4;
    localparam t_dir DIR_POS_Z = 3'd5;

    // Action codes carried in s_axis_tuser
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CENTER,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // Face selected from the pending void mask
    typedef struct packed {
        t_dir                 dir;
        logic                 last;
        logic [NUM_DIRS-1:0]  sel;
    } t_pick;

endpackage

`default_nettype wire

// ===== design/vfvc_face_pick.sv =====
// Picks the next exposed face from the pending void-neighbor mask.
// Depends on vfvc_pkg.
`default_nettype none

module vfvc_face_pick
    import vfvc_pkg::*;
(
    input  wire logic [NUM_DIRS-1:0] i_mask,
    output t_pick                    o_pick
);

    t_dir                dir;
    logic [NUM_DIRS-1:0] sel;

    // lowest set bit wins: scan order
    always_comb begin
        dir = DIR_POS_Y;
        sel = '0;
        for (int d = NUM_DIRS - 1; d >= 0; d--) begin
            if (i_mask[d]) begin
                dir = t_dir'(d);
                sel = NUM_DIRS'(1) << d;
            end
        end
    end

    assign o_pick.dir  = dir;
    assign o_pick.sel  = sel;
    assign o_pick.last = ((i_mask & ~sel) == '0);

endmodule

`default_nettype wire

// ===== design/voxel_face_visibility_culler_core.sv =====
// Voxel hidden-face culler top level: voxel store, query sequencer, face output.
// Depends on vfvc_pkg and vfvc_face_pick.
`default_nettype none

// The block holds a cubic world of voxel ids (SPAN = min(CHUNK_EDGE*WORLD_CHUNKS, 64)
// cells per axis) in one synchronous RAM with one write and one read port; the
// read data is registered. After reset it runs a clearing pass that writes zeros
// to all 2^(3*clog2(SPAN)) cells (262144 at the defaults), during which
// s_axis_tready is low. A write transaction (tuser = 0) stores the id and gives no
// output. A query transaction (tuser = 1) on a solid centre is accepted and reads
// the centre cell, tests it, then reads the neighbors one per cycle, since the
// single read port fetches one cell per cycle (+y, -y, -x, +x, -z, +z). An empty
// centre ends after its test, and a query outside the world ends when it is
// accepted. A solid centre then emits one output transaction per void neighbor
// (outside the world or zero), one per cycle while m_axis_tready is high, the final
// one with tlast set. The block works on one item at a time: no input is taken
// until the last face of a query has been taken. Coordinates outside the world are
// ignored.
module voxel_face_visibility_culler_core
    import vfvc_pkg::*;
#(
    parameter int CHUNK_EDGE   = 16,
    parameter int WORLD_CHUNKS = 4,
    parameter int VOXEL_BITS   = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // pos_x[5:0], pos_y[11:6], pos_z[17:12],
                                            // voxel_value[25:18], zero pad
    input  wire logic        s_axis_tuser,  // action: 0 write, 1 query

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // face_x[5:0], face_y[11:6], face_z[17:12],
                                            // face_dir[20:18], face_voxel[28:21], zero pad
    output logic             m_axis_tlast   // last_face
);

    localparam int WORLD_EDGE = CHUNK_EDGE * WORLD_CHUNKS;
    localparam int SPAN       = (WORLD_EDGE < 64) ? WORLD_EDGE : 64;
    localparam int SB         = $clog2(SPAN);
    localparam int ADDR_W     = 3 * SB;
    localparam int DEPTH      = 1 << ADDR_W;
    // input ids are 8 bits, so nothing above bit 7 can ever be stored
    localparam int SW         = (VOXEL_BITS < 8) ? VOXEL_BITS : 8;

    localparam logic [6:0] SPAN_V  = 7'(SPAN);
    localparam logic [6:0] STEP_UP = 7'd1;
    localparam logic [6:0] STEP_DN = 7'h7F;  // -1, wraps past the edge

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [5:0]          r_pos_x, n_pos_x;
    logic [5:0]          r_pos_y, n_pos_y;
    logic [5:0]          r_pos_z, n_pos_z;
    logic [7:0]          r_self, n_self;
    t_dir                r_rd_dir, n_rd_dir;     // direction of the data in r_rdata
    logic                r_rd_out, n_rd_out;     // that neighbor lies outside the world
    logic [NUM_DIRS-1:0] r_mask, n_mask;         // void neighbors still to emit

    logic [SW-1:0]       r_mem [DEPTH];
    logic [SW-1:0]       r_rdata;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic              in_acc, out_acc;
    logic [5:0]        in_x, in_y, in_z;
    logic [7:0]        in_val;
    logic              in_inside;
    logic [ADDR_W-1:0] in_addr;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_acc   = m_axis_tvalid && m_axis_tready;
    assign in_x      = s_axis_tdata[5:0];
    assign in_y      = s_axis_tdata[11:6];
    assign in_z      = s_axis_tdata[17:12];
    assign in_val    = s_axis_tdata[25:18];
    assign in_inside = ({1'b0, in_x} < SPAN_V) && ({1'b0, in_y} < SPAN_V)
                    && ({1'b0, in_z} < SPAN_V);
    assign in_addr   = {in_x[SB-1:0], in_y[SB-1:0], in_z[SB-1:0]};

    // ------------------------------------------------------------------
    // Neighbor address for the read issued this cycle
    // ------------------------------------------------------------------
    t_dir              iss_dir;
    logic [6:0]        nx, ny, nz;
    logic              nbr_out;
    logic [ADDR_W-1:0] nbr_addr;

    assign iss_dir = (r_state == ST_CENTER) ? DIR_POS_Y : t_dir'(r_rd_dir + 3'd1);

    always_comb begin
        nx = {1'b0, r_pos_x};
        ny = {1'b0, r_pos_y};
        nz = {1'b0, r_pos_z};
        unique case (iss_dir)
            DIR_POS_Y: ny = ny + STEP_UP;
            DIR_NEG_Y: ny = ny + STEP_DN;
            DIR_NEG_X: nx = nx + STEP_DN;
            DIR_POS_X: nx = nx + STEP_UP;
            DIR_NEG_Z: nz = nz + STEP_DN;
            DIR_POS_Z: nz = nz + STEP_UP;
            default: ;
        endcase
    end

    assign nbr_out  = (nx >= SPAN_V) || (ny >= SPAN_V) || (nz >= SPAN_V);
    assign nbr_addr = {nx[SB-1:0], ny[SB-1:0], nz[SB-1:0]};

    // ------------------------------------------------------------------
    // Face selection
    // ------------------------------------------------------------------
    t_pick pick;

    vfvc_face_pick u_face_pick (
        .i_mask (r_mask),
        .o_pick (pick)
    );

    logic scan_void;
    assign scan_void = r_rd_out || (r_rdata == '0);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr_addr == '1) n_state = ST_IDLE;
            ST_IDLE:   if (in_acc && (s_axis_tuser == ACT_QUERY) && in_inside) n_state = ST_CENTER;
            ST_CENTER: n_state = (r_rdata == '0) ? ST_IDLE : ST_SCAN;
            ST_SCAN: begin
                if (r_rd_dir == DIR_POS_Z) n_state = (n_mask != '0) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:   if (out_acc && pick.last) n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs: handshakes and memory port control
    // ------------------------------------------------------------------
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [SW-1:0]     mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = in_addr;
        mem_wdata     = in_val[SW-1:0];
        mem_raddr     = nbr_addr;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                mem_we        = in_acc && (s_axis_tuser == ACT_WRITE) && in_inside;
                mem_raddr     = in_addr;
            end
            ST_EMIT:   m_axis_tvalid = 1'b1;
            ST_CENTER,
            ST_SCAN:   ;
            default:   ;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        n_clr_addr = r_clr_addr;
        n_pos_x    = r_pos_x;
        n_pos_y    = r_pos_y;
        n_pos_z    = r_pos_z;
        n_self     = r_self;
        n_rd_dir   = r_rd_dir;
        n_rd_out   = r_rd_out;
        n_mask     = r_mask;
        unique case (r_state)
            ST_CLEAR: n_clr_addr = r_clr_addr + ADDR_W'(1);
            ST_IDLE: begin
                n_pos_x = in_x;
                n_pos_y = in_y;
                n_pos_z = in_z;
                n_mask  = '0;
            end
            ST_CENTER: begin
                n_self   = 8'(r_rdata);
                n_rd_dir = iss_dir;
                n_rd_out = nbr_out;
            end
            ST_SCAN: begin
                if (scan_void) n_mask = r_mask | (NUM_DIRS'(1) << r_rd_dir);
                n_rd_dir = iss_dir;
                n_rd_out = nbr_out;
            end
            ST_EMIT: if (out_acc) n_mask = r_mask & ~pick.sel;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_mask     <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_mask     <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos_x  <= n_pos_x;
        r_pos_y  <= n_pos_y;
        r_pos_z  <= n_pos_z;
        r_self   <= n_self;
        r_rd_dir <= n_rd_dir;
        r_rd_out <= n_rd_out;
    end

    // Voxel store
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Output transaction
    // ------------------------------------------------------------------
    assign m_axis_tdata = {3'b000, r_self, pick.dir, r_pos_z, r_pos_y, r_pos_x};
    assign m_axis_tlast = pick.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a face is pending");

    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (s_axis_tuser == ACT_QUERY) && in_inside) |=> (r_state == ST_CENTER))
        else $error("query did not start the centre read");

    a_emit_has_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_mask != '0))
        else $error("output valid with empty face mask");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && m_axis_tlast) |=> (r_state == ST_IDLE))
        else $error("query not finished after last face");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && (r_rd_dir == DIR_POS_Z))
            |=> ((r_state == ST_EMIT) || (r_state == ST_IDLE)))
        else $error("neighbor scan ran past the last direction");
`endif

endmodule

`default_nettype wire

// ===== sim/face_record_checker.sv =====
// Face record checker: watches both stream channels of the voxel face culler,
// keeps its own copy of the voxel world and compares every face transaction.
// Depends on vfvc_pkg (direction and action codes).
`default_nettype none

module face_record_checker
    import vfvc_pkg::*;
#(
    parameter int CHUNK_EDGE   = 16,
    parameter int WORLD_CHUNKS = 4,
    parameter int VOXEL_BITS   = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [31:0] i_in_data,   // pos_x[5:0], pos_y[11:6], pos_z[17:12],
                                          // voxel_value[25:18], zero pad
    input  wire logic        i_in_user,   // action
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [31:0] i_out_data,  // face_x, face_y, face_z, face_dir,
                                          // face_voxel, zero pad
    input  wire logic        i_out_last,  // last_face
    output int               o_mismatches,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORLD_EDGE = CHUNK_EDGE * WORLD_CHUNKS;
    localparam int SPAN       = (WORLD_EDGE < 64) ? WORLD_EDGE : 64;
    localparam int CELLS      = SPAN * SPAN * SPAN;
    localparam bit [15:0] VALUE_MASK = 16'((32'd1 << VOXEL_BITS) - 1);

    typedef struct packed {
        logic [5:0] x;
        logic [5:0] y;
        logic [5:0] z;
        t_dir       dir;
        logic [7:0] voxel;
        logic       last;
    } t_face;

    bit [15:0] world_cells [CELLS];
    t_face     pending_faces [$];
    int        mismatches = 0;

    function automatic bit in_world(input int x, input int y, input int z);
        return x >= 0 && x < SPAN && y >= 0 && y < SPAN && z >= 0 && z < SPAN;
    endfunction

    function automatic int cell_at(input int x, input int y, input int z);
        return (x * SPAN + y) * SPAN + z;
    endfunction

    // A neighbor is open when it is off the world or empty
    function automatic bit is_open(input int x, input int y, input int z);
        if (!in_world(x, y, z)) return 1'b1;
        return world_cells[cell_at(x, y, z)] == 16'd0;
    endfunction

    // Apply one accepted command to the world copy and queue its faces
    task automatic predict_faces(input logic act, input logic [31:0] data);
        int        x, y, z, nx, ny, nz;
        bit [15:0] self;
        t_face     rec;
        t_face     found [$];
        t_dir      d;
        x = int'(data[5:0]);
        y = int'(data[11:6]);
        z = int'(data[17:12]);
        if (!in_world(x, y, z)) return;
        if (act == ACT_WRITE) begin
            world_cells[cell_at(x, y, z)] = 16'(data[25:18]) & VALUE_MASK;
            return;
        end
        self = world_cells[cell_at(x, y, z)];
        if (self == 16'd0) return;
        for (int i = 0; i < NUM_DIRS; i++) begin
            d  = t_dir'(i);
            nx = x;
            ny = y;
            nz = z;
            case (d)
                DIR_POS_Y: ny = y + 1;
                DIR_NEG_Y: ny = y - 1;
                DIR_NEG_X: nx = x - 1;
                DIR_POS_X: nx = x + 1;
                DIR_NEG_Z: nz = z - 1;
                default:   nz = z + 1;
            endcase
            if (is_open(nx, ny, nz)) begin
                rec.x     = 6'(x);
                rec.y     = 6'(y);
                rec.z     = 6'(z);
                rec.dir   = d;
                rec.voxel = self[7:0];
                rec.last  = 1'b0;
                found     = {found, rec};
            end
        end
        if (found.size() > 0) found[found.size()-1].last = 1'b1;
        foreach (found[k]) pending_faces = {pending_faces, found[k]};
    endtask

    task automatic note_mismatch(input string what, input t_face want, input t_face got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t face %s: want x=%0d y=%0d z=%0d dir=%0d id=%0d last=%0d,",
                      " got x=%0d y=%0d z=%0d dir=%0d id=%0d last=%0d pad=%0h"},
                $realtime, what, want.x, want.y, want.z, want.dir, want.voxel, want.last,
                got.x, got.y, got.z, got.dir, got.voxel, got.last, i_out_data[31:29]);
    endtask

    always @(posedge i_clk) begin
        t_face got, want;
        if (i_rst_n) begin
            // Output side first: a result can never belong to the command
            // accepted at the same edge, since the block holds one at a time.
            if (i_out_valid && i_out_ready) begin
                got.x     = i_out_data[5:0];
                got.y     = i_out_data[11:6];
                got.z     = i_out_data[17:12];
                got.dir   = i_out_data[20:18];
                got.voxel = i_out_data[28:21];
                got.last  = i_out_last;
                if (pending_faces.size() == 0) begin
                    want = '0;
                    note_mismatch("unexpected", want, got);
                end else begin
                    want = pending_faces.pop_front();
                    if (got != want || i_out_data[31:29] != 3'd0)
                        note_mismatch("mismatch", want, got);
                end
            end
            if (i_in_valid && i_in_ready)
                predict_faces(i_in_user, i_in_data);
        end
        o_pending    <= pending_faces.size();
        o_mismatches <= mismatches;
    end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Top of the voxel face culler simulation: clock, reset, command stimulus,
// output backpressure, watchdog and verdict. Depends on vfvc_pkg,
// voxel_face_visibility_culler_core and face_record_checker.
`default_nettype none

module testbench
    import vfvc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // No-progress limit; long enough to cover the clearing pass several times over
    localparam int STALL_LIMIT   = 1_000_000;
    localparam int PHASE_ITEMS   = 88;
    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_CYCLES   = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // pos_x, pos_y, pos_z, voxel_value, zero pad
    logic        s_axis_tuser = 1'b0; // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // face_x, face_y, face_z, face_dir, face_voxel, pad
    logic        m_axis_tlast;        // last_face

    int mismatch_count;
    int faces_pending;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit rx_hold_req  = 1'b0;
    int rx_hold_left = 0;
    int idle_cycles  = 0;
    int items_sent   = 0;

    voxel_face_visibility_culler_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    face_record_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_last  (m_axis_tlast),
        .o_mismatches(mismatch_count),
        .o_pending   (faces_pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Output backpressure: random stalls per phase, plus one long hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req  = 1'b0;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Watchdog: cycles in which neither channel completes a transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one command and hold it until s_axis_tready is seen high when sampled after
    // the rising clock. Valid stays high across back-to-back transactions.
    task automatic offer(input logic act, input int x, input int y, input int z,
                         input int v);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {6'd0, v[7:0], z[5:0], y[5:0], x[5:0]};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Stop offering, then wait for every predicted face to come out
    // (the pending count is registered in the checker)
    task automatic drain_faces();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (faces_pending != 0);
    endtask

    // Cluster corner: mostly anywhere, sometimes hugging a world face
    function automatic int pick_base();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 0;
        if (r == 1) return 60;
        return $urandom_range(60);
    endfunction

    // Random part: mostly clusters of writes in a 4x4x4 box followed by
    // queries inside it (so neighbors are populated), the rest full-range noise.
    task automatic run_phase(input int n_items);
        int stop_at, bx, by, bz, n_wr, n_q, v;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 15) begin
                offer(logic'($urandom_range(1)), $urandom_range(63), $urandom_range(63),
                      $urandom_range(63), $urandom_range(255));
            end else begin
                bx   = pick_base();
                by   = pick_base();
                bz   = pick_base();
                n_wr = $urandom_range(3, 10);
                n_q  = $urandom_range(3, 8);
                repeat (n_wr) begin
                    v = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 255);
                    offer(ACT_WRITE, bx + $urandom_range(3), by + $urandom_range(3),
                          bz + $urandom_range(3), v);
                end
                repeat (n_q)
                    offer(ACT_QUERY, bx + $urandom_range(3), by + $urandom_range(3),
                          bz + $urandom_range(3), $urandom_range(255));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corners of the world, neighbors filled, buried voxel, erase
        offer(ACT_QUERY, 0, 0, 0, 8'hFF);          // empty cell, no faces
        offer(ACT_WRITE, 0, 0, 0, 255);
        offer(ACT_QUERY, 0, 0, 0, 0);              // all six faces, three off-world
        offer(ACT_WRITE, 63, 63, 63, 1);
        offer(ACT_QUERY, 63, 63, 63, 0);
        offer(ACT_WRITE, 1, 0, 0, 128);
        offer(ACT_WRITE, 0, 1, 0, 2);
        offer(ACT_QUERY, 0, 0, 0, 77);             // +y and +x now covered
        offer(ACT_WRITE, 32, 32, 32, 8'hA5);
        offer(ACT_WRITE, 32, 33, 32, 3);
        offer(ACT_WRITE, 32, 31, 32, 4);
        offer(ACT_WRITE, 31, 32, 32, 5);
        offer(ACT_WRITE, 33, 32, 32, 6);
        offer(ACT_WRITE, 32, 32, 31, 7);
        offer(ACT_WRITE, 32, 32, 33, 8);
        offer(ACT_QUERY, 32, 32, 32, 0);           // buried: no faces
        offer(ACT_QUERY, 32, 33, 32, 0);           // all but -y
        offer(ACT_WRITE, 32, 32, 32, 0);           // erase center
        offer(ACT_QUERY, 32, 32, 32, 0);
        offer(ACT_QUERY, 32, 33, 32, 0);           // now all six
        offer(ACT_WRITE, 63, 0, 63, 8'h5A);
        offer(ACT_QUERY, 63, 0, 63, 8'hA5);
        offer(ACT_WRITE, 42, 21, 42, 8'h81);
        offer(ACT_QUERY, 42, 21, 42, 0);
        drain_faces();

        // No idling; the long output hold-off starts as the phase begins
        rx_hold_req = 1'b1;
        run_phase(PHASE_ITEMS);
        drain_faces();

        tx_idle_pct = 53;
        run_phase(PHASE_ITEMS);
        drain_faces();

        tx_idle_pct  = 0;
        rx_stall_pct = 53;
        run_phase(PHASE_ITEMS);
        drain_faces();

        tx_idle_pct  = 32;
        rx_stall_pct = 32;
        run_phase(PHASE_ITEMS);

        s_axis_tvalid <= 1'b0;
        drain_faces();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && faces_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/vfvc_pkg.sv
design/vfvc_face_pick.sv
design/voxel_face_visibility_culler_core.sv
sim/face_record_checker.sv
sim/testbench.sv
